@@ rtl/atan2_polynomial_unit_defines.svh @@
// Assertion macros used by the atan2 pipeline top module.
`ifndef ATAN2_POLYNOMIAL_UNIT_DEFINES_SVH
`define ATAN2_POLYNOMIAL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AP_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("atan2 check failed");

// Next-cycle implication, checked outside reset.
`define AP_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("atan2 check failed");

`endif

@@ rtl/atan2_pkg.sv @@
`timescale 1ns / 1ps
package atan2_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int MAG_W           = COORD_WIDTH;
  localparam int RATIO_BITS      = 18;
  localparam int RATIO_W         = RATIO_BITS + 1;
  localparam int NUM_W           = MAG_W + RATIO_BITS;
  localparam int POLY_BITS       = 30;
  localparam int POLY_W          = 32;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_W         = ANGLE_FRAC_BITS + 3;
  localparam int HORNER_STEPS    = 9;
  localparam int WIDE_W          = POLY_W + 3;

  localparam logic signed [WIDE_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [WIDE_W-1:0] PI_Q30      = 35'sd3373259426;

  localparam logic signed [POLY_W-1:0] ATAN_COEF [HORNER_STEPS+1] = '{
    -32'sd11799, 32'sd366339, -32'sd4824569, 32'sd34999972, -32'sd151268974,
    32'sd386980859, -32'sd504850492, 32'sd539005, 32'sd1082082865, -32'sd511685
  };

  typedef struct packed {
    logic swap;
    logic yneg;
    logic xneg;
    logic zero;
  } side_t;

  typedef struct packed {
    logic               valid;
    logic [MAG_W-1:0]   rem;
    logic [RATIO_W-1:0] num;
    logic [RATIO_W-1:0] quo;
    logic [MAG_W-1:0]   den;
    side_t              side;
  } div_t;

  typedef struct packed {
    logic                     valid;
    logic [RATIO_W-1:0]       r;
    logic signed [POLY_W-1:0] u;
    side_t                    side;
  } hor_t;

endpackage

@@ rtl/atan2_polynomial_unit.sv @@
`timescale 1ns / 1ps
// Four-quadrant arctangent of a signed coordinate pair.
// Input channel: in_valid/in_ready carry y_coord and x_coord (16-bit signed).
// Output channel: out_valid/out_ready carry angle, radians times 8192, signed,
// within -pi..pi.
// Every input transaction gives exactly one output transaction, in order.
// The pipeline has an input register for magnitude and compare, 19 divider cells
// producing one ratio bit each, 9 Horner cells with one multiply each, and
// an output register for quadrant correction and rounding.
// Throughput is one transaction per cycle while the output is not stalled; the
// divider and polynomial chains are fully pipelined, so a new pair can enter every cycle.
// The whole chain advances together. When the output holds a result that the
// receiver does not take, every stage holds and in_ready drops; while the
// receiver takes results, or the output stage is empty, new pairs are taken.
// Synchronous reset empties the pipeline; no state is kept between
// transactions, so results are independent of history.
`include "atan2_polynomial_unit_defines.svh"
module atan2_polynomial_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [atan2_pkg::COORD_WIDTH-1:0] y_coord,
  input  logic signed [atan2_pkg::COORD_WIDTH-1:0] x_coord,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [atan2_pkg::ANGLE_W-1:0]     angle
);

  localparam int SHIFT = atan2_pkg::POLY_BITS - atan2_pkg::ANGLE_FRAC_BITS;

  logic en;

  atan2_pkg::div_t div_s [atan2_pkg::RATIO_W+1];
  atan2_pkg::hor_t hor_s [atan2_pkg::HORNER_STEPS+1];

  logic [atan2_pkg::MAG_W-1:0] ay, ax, mn, mx;
  logic [atan2_pkg::NUM_W-1:0] numer;
  logic                        swap;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    ay    = y_coord[atan2_pkg::COORD_WIDTH-1] ? (~y_coord + 1'b1) : y_coord;
    ax    = x_coord[atan2_pkg::COORD_WIDTH-1] ? (~x_coord + 1'b1) : x_coord;
    swap  = ay > ax;
    mn    = swap ? ax : ay;
    mx    = swap ? ay : ax;
    numer = ({{atan2_pkg::RATIO_BITS{1'b0}}, mn} << atan2_pkg::RATIO_BITS)
          + atan2_pkg::NUM_W'(mx >> 1);
  end

  // The quotient fits in 19 bits, so the top of the numerator is already
  // below the divisor and serves as the starting remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_s[0].valid <= 1'b0;
    end else if (en) begin
      div_s[0].valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_s[0].rem       <= numer[atan2_pkg::NUM_W-1:atan2_pkg::RATIO_W];
      div_s[0].num       <= numer[atan2_pkg::RATIO_W-1:0];
      div_s[0].quo       <= '0;
      div_s[0].den       <= mx;
      div_s[0].side.swap <= swap;
      div_s[0].side.yneg <= y_coord[atan2_pkg::COORD_WIDTH-1];
      div_s[0].side.xneg <= x_coord[atan2_pkg::COORD_WIDTH-1];
      div_s[0].side.zero <= (ay == '0) && (ax == '0);
    end
  end

  for (genvar i = 0; i < atan2_pkg::RATIO_W; i++) begin : g_div
    atan2_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .cin  (div_s[i]),
      .cout (div_s[i+1])
    );
  end

  always_comb begin
    hor_s[0].valid = div_s[atan2_pkg::RATIO_W].valid;
    hor_s[0].r     = div_s[atan2_pkg::RATIO_W].quo;
    hor_s[0].u     = atan2_pkg::ATAN_COEF[0];
    hor_s[0].side  = div_s[atan2_pkg::RATIO_W].side;
  end

  for (genvar i = 0; i < atan2_pkg::HORNER_STEPS; i++) begin : g_horner
    atan2_horner_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .coef (atan2_pkg::ATAN_COEF[i+1]),
      .cin  (hor_s[i]),
      .cout (hor_s[i+1])
    );
  end

  atan2_pkg::hor_t                    fin;
  logic signed [atan2_pkg::WIDE_W-1:0] a, q, qc, qr;
  logic signed [atan2_pkg::ANGLE_W-1:0] angle_next;

  always_comb begin
    fin = hor_s[atan2_pkg::HORNER_STEPS];
    a   = fin.side.swap ? (atan2_pkg::HALF_PI_Q30 - atan2_pkg::WIDE_W'(fin.u))
                        : atan2_pkg::WIDE_W'(fin.u);
    case ({fin.side.xneg, fin.side.yneg})
      2'b00:   q = a;
      2'b01:   q = -a;
      2'b10:   q = atan2_pkg::PI_Q30 - a;
      2'b11:   q = a - atan2_pkg::PI_Q30;
      default: q = a;
    endcase
    if (q > atan2_pkg::PI_Q30) begin
      qc = atan2_pkg::PI_Q30;
    end else if (q < -atan2_pkg::PI_Q30) begin
      qc = -atan2_pkg::PI_Q30;
    end else begin
      qc = q;
    end
    qr = (qc + (atan2_pkg::WIDE_W'(1) <<< (SHIFT - 1))) >>> SHIFT;
    angle_next = fin.side.zero ? '0 : qr[atan2_pkg::ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_next;
    end
  end

  // A zero pair divides by zero; its ratio is meaningless and discarded.
  `AP_IMPLY(a_angle_range, out_valid, (angle >= -16'sd25736) && (angle <= 16'sd25736))
  `AP_IMPLY(a_ratio_bound,
            div_s[atan2_pkg::RATIO_W].valid && !div_s[atan2_pkg::RATIO_W].side.zero,
            div_s[atan2_pkg::RATIO_W].quo <= (19'd1 << atan2_pkg::RATIO_BITS))
  `AP_NEXT(a_stall_holds, !en, $stable(fin) && $stable(div_s[0]))
  `AP_IMPLY(a_zero_side, fin.valid && fin.side.zero, angle_next == '0)

endmodule

@@ rtl/atan2_div_cell.sv @@
`timescale 1ns / 1ps
module atan2_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  atan2_pkg::div_t  cin,
  output atan2_pkg::div_t  cout
);

  logic [atan2_pkg::MAG_W:0]   shifted;
  logic [atan2_pkg::MAG_W:0]   diff;
  logic                        take;
  logic [atan2_pkg::MAG_W-1:0] rem_next;

  // One restoring division step: bring down the next numerator bit.
  always_comb begin
    shifted  = {cin.rem, cin.num[atan2_pkg::RATIO_W-1]};
    take     = shifted >= {1'b0, cin.den};
    diff     = shifted - {1'b0, cin.den};
    rem_next = take ? diff[atan2_pkg::MAG_W-1:0] : shifted[atan2_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (en) begin
      cout.valid <= cin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout.rem  <= rem_next;
      cout.num  <= {cin.num[atan2_pkg::RATIO_W-2:0], 1'b0};
      cout.quo  <= {cin.quo[atan2_pkg::RATIO_W-2:0], take};
      cout.den  <= cin.den;
      cout.side <= cin.side;
    end
  end

endmodule

@@ rtl/atan2_horner_cell.sv @@
`timescale 1ns / 1ps
module atan2_horner_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic signed [atan2_pkg::POLY_W-1:0] coef,
  input  atan2_pkg::hor_t                     cin,
  output atan2_pkg::hor_t                     cout
);

  localparam int PROD_W = atan2_pkg::POLY_W + atan2_pkg::RATIO_W + 1;

  logic signed [PROD_W-1:0]            prod;
  logic signed [PROD_W-1:0]            rnd;
  logic signed [atan2_pkg::POLY_W-1:0] u_next;

  // u = round(u * r / 2^18) + c, round half up via floor after adding half.
  always_comb begin
    prod   = PROD_W'(cin.u * $signed({1'b0, cin.r}));
    rnd    = prod + (PROD_W'(1) <<< (atan2_pkg::RATIO_BITS - 1));
    u_next = rnd[atan2_pkg::RATIO_BITS +: atan2_pkg::POLY_W] + coef;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (en) begin
      cout.valid <= cin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout.r    <= cin.r;
      cout.u    <= u_next;
      cout.side <= cin.side;
    end
  end

endmodule
